@@ rtl/scpr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpr_pkg
// shared constants and types for the second chance page replacement block
// ----------------------------------------------------------------------------
package scpr_pkg;

  localparam int FRAMES_DEFAULT = 16;
  localparam int PAGE_W         = 31;
  localparam int IDX_W          = 4;
  localparam int CFG_W          = 5;
  localparam int IN_TDATA_W     = 32;
  localparam int OUT_TDATA_W    = 40;
  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SWEEP,
    ST_DONE
  } state_t;

endpackage

@@ rtl/scpr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpr_ram
// single port synchronous ram, one access per cycle (a write also reads the old word), registered read
// ----------------------------------------------------------------------------
module scpr_ram #(
  parameter int WIDTH = scpr_pkg::PAGE_W,
  parameter int DEPTH = scpr_pkg::FRAMES_DEFAULT,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/second_chance_page_replacement_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// second_chance_page_replacement_top
// clock page replacement: page table in ram, valid and reference bits in flops
// ----------------------------------------------------------------------------
// sequence: accept, then search of the n active frames, then (on a fault)
//   a sweep from the clock hand, then output; a hit in frame i ends the search
// throughput: one reference at a time, set by the single ram port that the
//   search walks one frame per cycle, and the sweep at one frame per cycle
// reset: synchronous; valid and reference bits, hand and handshakes clear at
//   once, frames_in_use returns to 16, no clearing pass
// ----------------------------------------------------------------------------
module second_chance_page_replacement_top #(
  parameter int FRAMES = scpr_pkg::FRAMES_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // cfg_data: frames_in_use[4:0]
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [scpr_pkg::CFG_W-1:0]          cfg_data,
  // s_tdata: page_number[30:0], zero[31]
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [scpr_pkg::IN_TDATA_W-1:0]     s_tdata,
  // m_tdata: page_echo[30:0], frame_index[34:31], zero[39:35]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [scpr_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // m_tuser: fault[0]
  output logic                                m_tuser
);

  localparam int HW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NW = $clog2(FRAMES + 1);
  localparam int PW = scpr_pkg::PAGE_W;
  localparam int IW = scpr_pkg::IDX_W;

  scpr_pkg::state_t state, state_next;

  logic [scpr_pkg::CFG_W-1:0] frames_in_use;
  logic [NW-1:0]              n;
  logic [PW-1:0]              page;
  logic [NW-1:0]              rd_idx;
  logic [HW-1:0]              cmp_idx;
  logic                       cmp_pend;
  logic [HW-1:0]              hand;
  logic [HW-1:0]              hand_next;
  logic [FRAMES-1:0]          frame_valid;
  logic [FRAMES-1:0]          reference_bit;
  logic                       res_fault;
  logic [HW-1:0]              res_idx;
  logic [PW-1:0]              page_echo;
  logic [IW-1:0]              frame_index;
  logic                       fault;

  logic                       ram_we;
  logic [HW-1:0]              ram_addr;
  logic [PW-1:0]              ram_rdata;

  logic                       accept;
  logic                       hit;
  logic                       issue;
  logic                       go_sweep;
  logic                       place;
  logic                       push;

  // active frame count
  always_comb begin
    priority if (frames_in_use == '0) begin
      n = NW'(1);
    end else if (32'(frames_in_use) > 32'(FRAMES)) begin
      n = NW'(FRAMES);
    end else begin
      n = NW'(frames_in_use);
    end
  end

  assign hand_next = ((NW'(hand) + NW'(1)) >= n) ? '0 : HW'(NW'(hand) + NW'(1));

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == scpr_pkg::ST_IDLE);
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    hit        = 1'b0;
    issue      = 1'b0;
    go_sweep   = 1'b0;
    place      = 1'b0;
    push       = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = rd_idx[HW-1:0];
    unique case (state)
      scpr_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = scpr_pkg::ST_SEARCH;
        end
      end
      scpr_pkg::ST_SEARCH: begin
        if (cmp_pend && frame_valid[cmp_idx] && (ram_rdata == page)) begin
          hit        = 1'b1;
          state_next = scpr_pkg::ST_DONE;
        end else if (rd_idx < n) begin
          issue = 1'b1;
        end else begin
          go_sweep   = 1'b1;
          state_next = scpr_pkg::ST_SWEEP;
        end
      end
      scpr_pkg::ST_SWEEP: begin
        ram_addr = hand;
        if (!frame_valid[hand] || !reference_bit[hand]) begin
          place      = 1'b1;
          ram_we     = 1'b1;
          state_next = scpr_pkg::ST_DONE;
        end
      end
      scpr_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          push       = 1'b1;
          state_next = scpr_pkg::ST_IDLE;
        end
      end
      default: state_next = scpr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scpr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= scpr_pkg::FRAMES_IN_USE_RESET;
      frame_valid   <= '0;
      reference_bit <= '0;
      hand          <= '0;
      cmp_pend      <= 1'b0;
      rd_idx        <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frames_in_use <= cfg_data;
      end
      if (accept) begin
        rd_idx   <= '0;
        cmp_pend <= 1'b0;
      end
      if (issue) begin
        rd_idx   <= rd_idx + NW'(1);
        cmp_pend <= 1'b1;
      end
      if (hit) begin
        reference_bit[cmp_idx] <= 1'b1;
      end
      if (go_sweep && (NW'(hand) >= n)) begin
        hand <= '0;
      end
      if (state == scpr_pkg::ST_SWEEP) begin
        hand <= hand_next;
        if (place) begin
          frame_valid[hand]   <= 1'b1;
          reference_bit[hand] <= 1'b1;
        end else begin
          reference_bit[hand] <= 1'b0;
        end
      end
      if (push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      page <= s_tdata[PW-1:0];
    end
    if (issue) begin
      cmp_idx <= rd_idx[HW-1:0];
    end
    if (hit) begin
      res_fault <= 1'b0;
      res_idx   <= cmp_idx;
    end
    if (place) begin
      res_fault <= 1'b1;
      res_idx   <= hand;
    end
    if (push) begin
      fault       <= res_fault;
      page_echo   <= page;
      frame_index <= IW'(res_idx);
    end
  end

  assign m_tdata = {(scpr_pkg::OUT_TDATA_W - PW - IW)'(0), frame_index, page_echo};
  assign m_tuser = fault;

  scpr_ram #(
    .WIDTH (PW),
    .DEPTH (FRAMES)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (page),
    .rdata (ram_rdata)
  );

  a_sweep_hand_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == scpr_pkg::ST_SWEEP) |-> (NW'(hand) < n))
    else $error("clock hand outside active frames during sweep");

  a_placed_frame_marked: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> (frame_valid[$past(ram_addr)] && reference_bit[$past(ram_addr)]))
    else $error("placed frame not marked valid and referenced");

  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    (state == scpr_pkg::ST_SEARCH) |-> (rd_idx <= n))
    else $error("search index ran past active frames");

  a_hit_sets_ref: assert property (@(posedge clk) disable iff (rst)
    hit |=> reference_bit[$past(cmp_idx)])
    else $error("hit did not set reference bit");

  a_accept_starts_search: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == scpr_pkg::ST_SEARCH) && (rd_idx == '0) && !cmp_pend)
    else $error("accepted word did not start a fresh search");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives page references into the second chance page replacement block
// and checks every hit or fault word against a clock-algorithm predictor
// across a range of active frame counts, with random stalls on both sides
// ----------------------------------------------------------------------------
module tb;

  localparam int NFRAMES     = scpr_pkg::FRAMES_DEFAULT;
  localparam int PW          = scpr_pkg::PAGE_W;
  localparam int IW          = scpr_pkg::IDX_W;
  localparam int CW          = scpr_pkg::CFG_W;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 2 * NFRAMES + 24;
  localparam int LONG_HOLD   = 400;
  localparam int POOL_SIZE   = 24;
  localparam logic [PW-1:0] PAGE_MAX = {PW{1'b1}};

  typedef struct {
    logic          fault;
    logic [PW-1:0] page;
    logic [IW-1:0] frame;
  } page_result_t;

  class page_ref_scoreboard;
    logic [CW-1:0]  frames_reg;
    logic [PW-1:0]  slot_page [NFRAMES];
    bit             slot_live [NFRAMES];
    bit             slot_used [NFRAMES];
    int unsigned    hand_pos;
    page_result_t   expected_refs [$];
    int             errors;

    function void clear_table();
      for (int i = 0; i < NFRAMES; i++) begin
        slot_page[i] = '0;
        slot_live[i] = 1'b0;
        slot_used[i] = 1'b0;
      end
      hand_pos   = 0;
      frames_reg = scpr_pkg::FRAMES_IN_USE_RESET;
      errors     = 0;
      expected_refs.delete();
    endfunction

    function void set_frames(logic [CW-1:0] v);
      frames_reg = v;
    endfunction

    function int pending();
      return expected_refs.size();
    endfunction

    function void note_reference(logic [PW-1:0] pg);
      int unsigned  active_cnt;
      int unsigned  h;
      bit           done;
      page_result_t r;
      active_cnt = 32'(frames_reg);
      if (active_cnt == 0) active_cnt = 1;
      if (active_cnt > NFRAMES) active_cnt = NFRAMES;
      done    = 1'b0;
      r.fault = 1'b1;
      r.page  = pg;
      r.frame = '0;
      for (int i = 0; i < active_cnt; i++) begin
        if (!done && slot_live[i] && slot_page[i] == pg) begin
          slot_used[i] = 1'b1;
          r.fault      = 1'b0;
          r.frame      = i[IW-1:0];
          done         = 1'b1;
        end
      end
      if (!done) begin
        if (hand_pos >= active_cnt) hand_pos = 0;
        for (int s = 0; s <= 2 * active_cnt; s++) begin
          if (!done) begin
            h        = hand_pos;
            hand_pos = (h + 1 >= active_cnt) ? 0 : h + 1;
            if (!slot_live[h] || !slot_used[h]) begin
              slot_page[h] = pg;
              slot_live[h] = 1'b1;
              slot_used[h] = 1'b1;
              r.frame      = h[IW-1:0];
              done         = 1'b1;
            end else begin
              slot_used[h] = 1'b0;
            end
          end
        end
      end
      expected_refs.push_back(r);
    endfunction

    function void check_word(logic fault, logic [PW-1:0] pg, logic [IW-1:0] frame);
      page_result_t e;
      if (expected_refs.size() == 0) begin
        $error("unexpected result word: fault %0d page %0h frame %0d", fault, pg, frame);
        errors++;
      end else begin
        e = expected_refs.pop_front();
        if (fault !== e.fault) begin
          $error("fault: expected %0d, actual %0d", e.fault, fault);
          errors++;
        end
        if (pg !== e.page) begin
          $error("page_echo: expected %0h, actual %0h", e.page, pg);
          errors++;
        end
        if (frame !== e.frame) begin
          $error("frame_index: expected %0d, actual %0d", e.frame, frame);
          errors++;
        end
      end
    endfunction
  endclass

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [CW-1:0]                        cfg_data = '0;
  logic                                 s_tvalid = 1'b0;
  logic                                 s_tready;
  logic [scpr_pkg::IN_TDATA_W-1:0]      s_tdata = '0;
  logic                                 m_tvalid;
  logic                                 m_tready = 1'b0;
  logic [scpr_pkg::OUT_TDATA_W-1:0]     m_tdata;
  logic                                 m_tuser;

  page_ref_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int cycle_count = 0;
  logic [PW-1:0] pool [POOL_SIZE];

  second_chance_page_replacement_top #(.FRAMES(NFRAMES)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // result side: random stall bursts plus one long hold on request
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready)
        sb.check_word(m_tuser, m_tdata[PW-1:0], m_tdata[PW+IW-1:PW]);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!rst && $urandom_range(0, 99) < recv_idle_pct) begin
        stall_left = $urandom_range(0, 7);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_page(input logic [PW-1:0] pg);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, pg};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_reference(pg);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_frames(input logic [CW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_frames(v);
  endtask

  function automatic logic [PW-1:0] pick_page(int ws);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 85) return pool[$urandom_range(0, ws - 1)];
    if (sel < 95) return PW'($urandom());
    return ($urandom_range(0, 1) != 0) ? PAGE_MAX : '0;
  endfunction

  initial begin : stimulus
    logic [CW-1:0] phase_cfg [12];
    logic [CW-1:0] cfg_now;
    int ws;
    int items;
    phase_cfg = '{5'd16, 5'd1, 5'd8, 5'd0, 5'd31, 5'd3, 5'd17, 5'd12, 5'd2, 5'd5, 5'd15, 5'd4};
    sb.clear_table();
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = PW'($urandom());
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, hits, hand restart, zero and oversized counts
    send_page('0);
    send_page(PAGE_MAX);
    send_page('0);
    send_page(31'h2AAAAAAA);
    send_page(31'h55555555);
    send_page(PAGE_MAX);
    drain();
    write_frames(5'd2);
    send_page(31'd10);
    send_page(31'd11);
    send_page(31'd12);
    send_page(31'd10);
    drain();
    write_frames(5'd0);
    send_page(31'd20);
    send_page(31'd20);
    send_page(31'd21);
    drain();
    write_frames(5'd31);
    send_page(31'h2AAAAAAA);
    send_page(31'h55555555);
    send_page(31'd21);
    drain();
    write_frames(5'd17);
    send_page(31'd5);
    send_page(PAGE_MAX);

    // random phases over several frame counts
    for (int k = 0; k < 12; k++) begin
      drain();
      cfg_now = (k < 8) ? phase_cfg[k] : CW'($urandom_range(0, 31));
      write_frames(cfg_now);
      for (int i = 0; i < POOL_SIZE; i++)
        if ($urandom_range(0, 1) != 0) pool[i] = PW'($urandom());
      ws = $urandom_range(1, POOL_SIZE);
      case ($urandom_range(0, 2))
        0: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        1: begin
          send_idle_pct = 12;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 35;
          recv_idle_pct = 35;
        end
      endcase
      if (k == 3) hold_req = 1'b1;
      items = 100;
      for (int n = 0; n < items; n++) begin
        if (k == 5 && n == items / 2) drain();
        send_page(pick_page(ws));
      end
    end

    // closing stretch with no idling
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_frames(5'd16);
    for (int n = 0; n < 60; n++) send_page(pick_page(POOL_SIZE));

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
